### hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the pressure compensation pipeline
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RawWidth    = 20;
    localparam int WordWidth   = 32;
    localparam int QuoWidth    = 32;
    localparam int ArithStages = 13;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TEMP     = 2'd0,
        CFG_PRESS_LO = 2'd1,
        CFG_PRESS_HI = 2'd2,
        CFG_PRESS_P9 = 2'd3
    } cfg_index_t;

    // Calibration coefficients, all sign or zero extended to 32 bits.
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } calib_t;

    // Arithmetic shift right on a 32-bit word.
    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

### hdl/ptc_divider.sv
// ----------------------------------------------------------------------------
// ptc_divider: pipelined unsigned 32 by 32 restoring divider
// ----------------------------------------------------------------------------
// One quotient bit is settled per stage; each stage moves in step with the
// shared enable and carries its own tag.
module ptc_divider
    import ptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           dividend,
    input  logic [31:0]           divisor,
    input  logic [95:0]           in_tag,
    output logic                  out_valid,
    output logic [31:0]           quotient,
    output logic [95:0]           out_tag
);
    logic [QuoWidth:0]  vld_reg;
    logic [31:0]        rem_reg [QuoWidth+1];
    logic [31:0]        quo_reg [QuoWidth+1];
    logic [31:0]        den_reg [QuoWidth+1];
    logic [95:0]        tag_reg [QuoWidth+1];

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QuoWidth-1:0], in_valid};
        end
    end

    // Stage 0 loads the operands; each later stage decides one bit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= dividend;
            den_reg[0] <= divisor;
            tag_reg[0] <= in_tag;
            for (int i = 0; i < QuoWidth; i++)
            begin
                logic [32:0] trial;
                trial = {rem_reg[i], quo_reg[i][31]} - {1'b0, den_reg[i]};
                if (!trial[32])
                begin
                    rem_reg[i+1] <= trial[31:0];
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= {rem_reg[i][30:0], quo_reg[i][31]};
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b0};
                end
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[QuoWidth];
    assign quotient  = quo_reg[QuoWidth];
    assign out_tag   = tag_reg[QuoWidth];
endmodule

### hdl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: 32-bit integer barometric compensation
// ----------------------------------------------------------------------------
// Pipeline: a result passes through 51 register stages (14 arithmetic, 33 divider,
// 3 post-division, one output).
// Throughput: one reading per cycle; the whole pipeline advances together and
// holds while the output stalls.
// Reset clears all valid bits and the calibration registers to zero.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // tdata: raw_temperature[19:0], raw_pressure[39:20], zero pad [47:40]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    // tdata: temperature_centi[15:0], fine_temperature[47:16],
    //        pressure_pa[79:48], pressure_valid[80], zero pad [87:81]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [47:0] tcal_reg;
    logic [63:0] plo_reg, phi_reg;
    logic [15:0] p9_reg;
    calib_t      c;
    logic        en;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg <= '0;
            plo_reg  <= '0;
            phi_reg  <= '0;
            p9_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TEMP:     tcal_reg <= cfg_data[47:0];
                CFG_PRESS_LO: plo_reg  <= cfg_data;
                CFG_PRESS_HI: phi_reg  <= cfg_data;
                CFG_PRESS_P9: p9_reg   <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        c.t1 = {16'd0, tcal_reg[15:0]};
        c.t2 = sx16(tcal_reg[31:16]);
        c.t3 = sx16(tcal_reg[47:32]);
        c.p1 = {16'd0, plo_reg[15:0]};
        c.p2 = sx16(plo_reg[31:16]);
        c.p3 = sx16(plo_reg[47:32]);
        c.p4 = sx16(plo_reg[63:48]);
        c.p5 = sx16(phi_reg[15:0]);
        c.p6 = sx16(phi_reg[31:16]);
        c.p7 = sx16(phi_reg[47:32]);
        c.p8 = sx16(phi_reg[63:48]);
        c.p9 = sx16(p9_reg);
    end

    // Whole pipeline moves when the output register is free.
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Per-stage valid and working registers.
    logic [ArithStages:0] v_reg;
    logic [31:0] adct_reg [ArithStages+1], adcp_reg [ArithStages+1];
    logic [31:0] x_reg [ArithStages+1], y_reg [ArithStages+1];
    logic [31:0] z_reg [ArithStages+1], w_reg [ArithStages+1];
    logic [31:0] fine_reg [ArithStages+1], tc_reg [ArithStages+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ArithStages-1:0], s_axis_tvalid};
    end

    // Arithmetic stages, at most two multiplies each.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adct_reg[0] <= {12'd0, s_axis_tdata[19:0]};
            adcp_reg[0] <= {12'd0, s_axis_tdata[39:20]};
            x_reg[0]    <= '0;
            y_reg[0]    <= '0;
            z_reg[0]    <= '0;
            w_reg[0]    <= '0;
            fine_reg[0] <= '0;
            tc_reg[0]   <= '0;
            for (int i = 0; i < ArithStages; i++)
            begin
                adct_reg[i+1] <= adct_reg[i];
                adcp_reg[i+1] <= adcp_reg[i];
                x_reg[i+1]    <= x_reg[i];
                y_reg[i+1]    <= y_reg[i];
                z_reg[i+1]    <= z_reg[i];
                w_reg[i+1]    <= w_reg[i];
                fine_reg[i+1] <= fine_reg[i];
                tc_reg[i+1]   <= tc_reg[i];
            end
            // Stage 1: temperature differences.
            x_reg[1] <= (adct_reg[0] >> 3) - (c.t1 << 1);
            y_reg[1] <= (adct_reg[0] >> 4) - c.t1;
            // Stage 2: first products.
            x_reg[2] <= asr32(x_reg[1] * c.t2, 11);
            y_reg[2] <= asr32(y_reg[1] * y_reg[1], 12);
            // Stage 3: cubic term.
            y_reg[3] <= asr32(y_reg[2] * c.t3, 14);
            // Stage 4: fine temperature.
            fine_reg[4] <= x_reg[3] + y_reg[3];
            // Stage 5: centi degrees and pressure offset base.
            tc_reg[5] <= asr32(fine_reg[4] * 32'd5 + 32'd128, 8);
            x_reg[5]  <= asr32(fine_reg[4], 1) - 32'd64000;
            // Stage 6: square.
            y_reg[6] <= asr32(x_reg[5], 2) * asr32(x_reg[5], 2);
            // Stage 7: p6 and p5 products.
            z_reg[7] <= asr32(y_reg[6], 11) * c.p6;
            w_reg[7] <= x_reg[6] * c.p5;
            // Stage 8: b and p3 product.
            z_reg[8] <= asr32(z_reg[7] + (w_reg[7] << 1), 2) + (c.p4 << 16);
            w_reg[8] <= c.p3 * asr32(y_reg[7], 13);
            // Stage 9: p2 product.
            y_reg[9] <= c.p2 * x_reg[8];
            // Stage 10: sum and shift.
            x_reg[10] <= asr32(asr32(w_reg[9], 3) + asr32(y_reg[9], 1), 18);
            // Stage 11: divisor.
            x_reg[11] <= asr32((32'd32768 + x_reg[10]) * c.p1, 15);
            // Stage 12: numerator base.
            y_reg[12] <= (32'd1048576 - adcp_reg[11]) - asr32(z_reg[11], 12);
            // Stage 13: times 3125.
            y_reg[13] <= y_reg[12] * 32'd3125;
        end
    end

    // Divider input: dividend chosen by the top bit of p.
    logic [31:0] d_num;
    logic        d_big;
    assign d_big = y_reg[13][31];
    assign d_num = d_big ? y_reg[13] : (y_reg[13] << 1);

    logic        dq_vld;
    logic [31:0] dq;
    logic [95:0] dtag;

    ptc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_reg[13]),
        .dividend (d_num),
        .divisor  (x_reg[13]),
        .in_tag   ({30'd0, d_big, x_reg[13] == 32'd0, fine_reg[13], tc_reg[13]}),
        .out_valid(dq_vld),
        .quotient (dq),
        .out_tag  (dtag)
    );

    // Post-division stages.
    logic        q1_vld_reg, q2_vld_reg, q3_vld_reg;
    logic [31:0] q1_p_reg, q2_p_reg, q3_p_reg;
    logic [31:0] q1_sq_reg, q2_a_reg, q2_b_reg;
    logic [64:0] q1_tag_reg, q2_tag_reg, q3_tag_reg;
    logic [31:0] pdiv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            q3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q1_vld_reg <= dq_vld;
            q2_vld_reg <= q1_vld_reg;
            q3_vld_reg <= q2_vld_reg;
        end
    end

    assign pdiv = dtag[65] ? (dq << 1) : dq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_p_reg   <= pdiv;
            q1_sq_reg  <= (pdiv >> 3) * (pdiv >> 3);
            q1_tag_reg <= dtag[64:0];
            q2_p_reg   <= q1_p_reg;
            q2_a_reg   <= c.p9 * (q1_sq_reg >> 13);
            q2_b_reg   <= (q1_p_reg >> 2) * c.p8;
            q2_tag_reg <= q1_tag_reg;
            q3_p_reg   <= q2_p_reg + asr32(asr32(q2_a_reg, 12)
                          + asr32(q2_b_reg, 13) + c.p7, 4);
            q3_tag_reg <= q2_tag_reg;
        end
    end

    // Saturate temperature and assemble the result.
    logic [15:0] tsat;
    logic [31:0] tcw;
    assign tcw = q3_tag_reg[31:0];
    always_comb
    begin
        if ($signed(tcw) > 32'sd32767)
            tsat = 16'h7FFF;
        else if ($signed(tcw) < -32'sd32768)
            tsat = 16'h8000;
        else
            tsat = tcw[15:0];
    end

    logic [87:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= q3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {7'd0, !q3_tag_reg[64],
                             q3_tag_reg[64] ? 32'd0 : q3_p_reg,
                             q3_tag_reg[63:32], tsat};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A stalled result keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed during stall");
    // Invalid pressure always reads zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[80] |-> m_axis_tdata[79:48] == 32'd0)
        else $error("invalid pressure not zero");
    // Input is taken whenever the output can move.
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled without back pressure");
`endif
endmodule
